// File: design/seg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope generator package
// Shared widths, register indexes, controller states and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package seg_pkg;

  localparam int NOW_IN_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LEVEL_W = 17;
  localparam int QUOT_W = 16;
  localparam int CS_W = 34;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] MOD_STEPS = CNT_W'(33);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUOT_W);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(17'h10000);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN_LEN = 3'd4;

  localparam logic [31:0] PERIOD_LEN_RST = 32'd1250;
  localparam logic [31:0] START_PHASE_RST = 32'd0;
  localparam logic [31:0] RAMP_UP_LEN_RST = 32'd100;
  localparam logic [31:0] HOLD_LEN_RST = 32'd0;
  localparam logic [31:0] RAMP_DOWN_LEN_RST = 32'd50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHECK,
    ST_MOD,
    ST_FIX,
    ST_UP,
    ST_HOLD,
    ST_DOWN,
    ST_DIV,
    ST_OUT
  } seg_state_t;

  typedef enum logic [1:0] {
    RES_KEEP,
    RES_ZERO,
    RES_FULL,
    RES_QUOT
  } seg_res_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         calc_diff;
    logic         zero_per;
    logic         mod_start;
    logic         step;
    logic         step_mod;
    logic         mod_fix;
    logic         up_sub;
    logic         hold_sub;
    logic         div_up;
    logic         div_down;
    seg_res_sel_t res_sel;
    logic         out_load;
  } seg_cmd_t;

  typedef struct packed {
    logic diff_neg;
    logic per_zero;
    logic diff_ge_per;
    logic cnt_last;
    logic lt_up;
    logic lt_hold;
    logic lt_down;
    logic d_zero;
    logic out_busy;
  } seg_status_t;

endpackage

// File: design/seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope generator channels
// Valid/ready channels for time requests, envelope results and register writes.
// ----------------------------------------------------------------------------
interface seg_in_if;
  logic                         valid;
  logic                         ready;
  logic [seg_pkg::NOW_IN_W-1:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink (input valid, input now_time, output ready);
endinterface

interface seg_out_if;
  logic                        valid;
  logic                        ready;
  logic [seg_pkg::LEVEL_W-1:0] level;
  logic                        visible;

  modport source (output valid, output level, output visible, input ready);
  modport sink (input valid, input level, input visible, output ready);
endinterface

interface seg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [seg_pkg::CFG_IDX_W-1:0]  idx;
  logic [seg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// File: design/seg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope controller
// Sequences one request through phase wrap, segment selection, the shared
// serial divider and the output register.
// ----------------------------------------------------------------------------
module seg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  seg_pkg::seg_status_t sts,
  output seg_pkg::seg_cmd_t    cmd
);

  seg_pkg::seg_state_t state_r;
  seg_pkg::seg_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= seg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      seg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = seg_pkg::ST_DIFF;
      end
      seg_pkg::ST_DIFF: state_nxt = seg_pkg::ST_CHECK;
      seg_pkg::ST_CHECK: begin
        if (sts.diff_neg) state_nxt = seg_pkg::ST_OUT;
        else if (sts.per_zero) state_nxt = seg_pkg::ST_UP;
        else if (sts.diff_ge_per) state_nxt = seg_pkg::ST_MOD;
        else state_nxt = seg_pkg::ST_UP;
      end
      seg_pkg::ST_MOD: begin
        if (sts.cnt_last) state_nxt = seg_pkg::ST_FIX;
      end
      seg_pkg::ST_FIX: state_nxt = seg_pkg::ST_UP;
      seg_pkg::ST_UP: begin
        state_nxt = sts.lt_up ? seg_pkg::ST_DIV : seg_pkg::ST_HOLD;
      end
      seg_pkg::ST_HOLD: begin
        state_nxt = sts.lt_hold ? seg_pkg::ST_OUT : seg_pkg::ST_DOWN;
      end
      seg_pkg::ST_DOWN: begin
        if (sts.lt_down && !sts.d_zero) state_nxt = seg_pkg::ST_DIV;
        else state_nxt = seg_pkg::ST_OUT;
      end
      seg_pkg::ST_DIV: begin
        if (sts.cnt_last) state_nxt = seg_pkg::ST_OUT;
      end
      seg_pkg::ST_OUT: begin
        if (!sts.out_busy) state_nxt = seg_pkg::ST_IDLE;
      end
      default: state_nxt = seg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = seg_pkg::RES_KEEP;
    in_ready = 1'b0;
    unique case (state_r)
      seg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      seg_pkg::ST_DIFF: cmd.calc_diff = 1'b1;
      seg_pkg::ST_CHECK: begin
        if (sts.diff_neg) cmd.res_sel = seg_pkg::RES_ZERO;
        else if (sts.per_zero) cmd.zero_per = 1'b1;
        else if (sts.diff_ge_per) cmd.mod_start = 1'b1;
      end
      seg_pkg::ST_MOD: begin
        cmd.step = 1'b1;
        cmd.step_mod = 1'b1;
      end
      seg_pkg::ST_FIX: cmd.mod_fix = 1'b1;
      seg_pkg::ST_UP: begin
        if (sts.lt_up) cmd.div_up = 1'b1;
        else cmd.up_sub = 1'b1;
      end
      seg_pkg::ST_HOLD: begin
        if (sts.lt_hold) cmd.res_sel = seg_pkg::RES_FULL;
        else cmd.hold_sub = 1'b1;
      end
      seg_pkg::ST_DOWN: begin
        // A zero offset into the fall is still the full level.
        if (!sts.lt_down) cmd.res_sel = seg_pkg::RES_ZERO;
        else if (sts.d_zero) cmd.res_sel = seg_pkg::RES_FULL;
        else cmd.div_down = 1'b1;
      end
      seg_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.cnt_last) cmd.res_sel = seg_pkg::RES_QUOT;
      end
      seg_pkg::ST_OUT: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/seg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope datapath
// Configuration registers, cycle start, offset arithmetic, a shared
// one-bit-per-cycle restoring divider and the output register.
// ----------------------------------------------------------------------------
module seg_datapath #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  seg_pkg::seg_cmd_t              cmd,
  output seg_pkg::seg_status_t           sts,
  input  logic [seg_pkg::NOW_IN_W-1:0]   in_now_time,
  input  logic                           cfg_we,
  input  logic [seg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [seg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [seg_pkg::LEVEL_W-1:0]    out_level,
  output logic                           out_visible
);

  localparam int NOW_W = (TIME_BITS < seg_pkg::NOW_IN_W) ? TIME_BITS : seg_pkg::NOW_IN_W;
  localparam int CS_W = seg_pkg::CS_W;
  localparam int QW = seg_pkg::QUOT_W;
  localparam int LW = seg_pkg::LEVEL_W;

  logic [31:0]                  period_r, up_r, hold_r, down_r;
  logic signed [CS_W-1:0]       cs_r, cs_nxt;
  logic [NOW_W-1:0]             now_r;
  logic [CS_W-1:0]              d_r, d_nxt;
  logic [31:0]                  rem_r, rem_nxt;
  logic [31:0]                  div_r, div_nxt;
  logic [QW-1:0]                q_r, q_nxt;
  logic [seg_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]                res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [LW-1:0]                level_r;
  logic                         visible_r;

  logic signed [CS_W-1:0]       now_ext;
  logic [32:0]                  sh;
  logic                         ge;
  logic [32:0]                  sh_sub;

  assign now_ext = signed'({{(CS_W-NOW_W){1'b0}}, now_r});

  // Shared divider step: shift in one dividend bit, subtract when it fits.
  assign sh = {rem_r, (cmd.step_mod ? d_r[32] : 1'b0)};
  assign ge = (sh >= {1'b0, div_r});
  assign sh_sub = sh - {1'b0, div_r};
  assign q_nxt = {q_r[QW-2:0], ge};

  always_comb begin
    sts.diff_neg = d_r[CS_W-1];
    sts.per_zero = (period_r == 32'd0);
    sts.diff_ge_per = (d_r[32:0] >= {1'b0, period_r});
    sts.cnt_last = (cnt_r == seg_pkg::CNT_W'(1));
    sts.lt_up = (d_r[31:0] < up_r);
    sts.lt_hold = (d_r[31:0] < hold_r);
    sts.lt_down = (d_r[31:0] < down_r);
    sts.d_zero = (d_r[31:0] == 32'd0);
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    cs_nxt = cs_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (cmd.calc_diff) d_nxt = unsigned'(now_ext - cs_r);
    if (cmd.zero_per) begin
      cs_nxt = now_ext;
      d_nxt = '0;
    end
    if (cmd.mod_start) begin
      rem_nxt = '0;
      div_nxt = period_r;
      cnt_nxt = seg_pkg::MOD_STEPS;
    end
    if (cmd.step) begin
      rem_nxt = ge ? sh_sub[31:0] : sh[31:0];
      cnt_nxt = cnt_r - seg_pkg::CNT_W'(1);
      if (cmd.step_mod) d_nxt = {d_r[CS_W-2:0], 1'b0};
    end
    if (cmd.mod_fix) begin
      d_nxt = {{(CS_W-32){1'b0}}, rem_r};
      cs_nxt = now_ext - signed'({{(CS_W-32){1'b0}}, rem_r});
    end
    if (cmd.up_sub) d_nxt = {{(CS_W-32){1'b0}}, d_r[31:0] - up_r};
    if (cmd.hold_sub) d_nxt = {{(CS_W-32){1'b0}}, d_r[31:0] - hold_r};
    if (cmd.div_up) begin
      rem_nxt = d_r[31:0];
      div_nxt = up_r;
      cnt_nxt = seg_pkg::DIV_STEPS;
    end
    if (cmd.div_down) begin
      rem_nxt = down_r - d_r[31:0];
      div_nxt = down_r;
      cnt_nxt = seg_pkg::DIV_STEPS;
    end
    if (cfg_we && (cfg_idx == seg_pkg::REG_START_PHASE)) begin
      cs_nxt = CS_W'(signed'(cfg_data));
    end
  end

  always_comb begin
    case (cmd.res_sel)
      seg_pkg::RES_ZERO: res_nxt = '0;
      seg_pkg::RES_FULL: res_nxt = seg_pkg::FULL_LEVEL;
      seg_pkg::RES_QUOT: res_nxt = {{(LW-QW){1'b0}}, q_nxt};
      default: res_nxt = res_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= seg_pkg::PERIOD_LEN_RST;
      up_r <= seg_pkg::RAMP_UP_LEN_RST;
      hold_r <= seg_pkg::HOLD_LEN_RST;
      down_r <= seg_pkg::RAMP_DOWN_LEN_RST;
      cs_r <= CS_W'(signed'(seg_pkg::START_PHASE_RST));
      out_valid_r <= 1'b0;
    end else begin
      cs_r <= cs_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          seg_pkg::REG_PERIOD_LEN: period_r <= cfg_data;
          seg_pkg::REG_RAMP_UP_LEN: up_r <= cfg_data;
          seg_pkg::REG_HOLD_LEN: hold_r <= cfg_data;
          seg_pkg::REG_RAMP_DOWN_LEN: down_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) now_r <= in_now_time[NOW_W-1:0];
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.step) q_r <= q_nxt;
    res_r <= res_nxt;
    if (cmd.out_load) begin
      level_r <= res_r;
      visible_r <= (res_r != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = level_r;
  assign out_visible = visible_r;

endmodule

// File: design/strobe_envelope_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope generator
// Periodic trapezoid brightness envelope for one strobe light.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload               Meaning
//  in_ch     in   now_time[31:0]        current time in ticks
//  out_ch    out  level[16:0], visible  Q1.16 level, level above zero
//  cfg_ch    in   idx[2:0], data[31:0]  register write, always ready
//
//  A time before the cycle start takes the short path straight to the output
//  register. The longest path is the 33-step phase wrap plus the 16-step
//  level quotient, both run on one shared restoring divider that retires
//  one bit per cycle.
//  Reset is synchronous; it restores register defaults and the cycle start.
//  A new request is taken while an earlier result waits in the output
//  register; a stalled output holds the controller only at its last step.
// ----------------------------------------------------------------------------
module strobe_envelope_generator_unit #(
  parameter int TIME_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  seg_in_if.sink   in_ch,
  seg_out_if.source out_ch,
  seg_cfg_if.sink  cfg_ch
);

  seg_pkg::seg_cmd_t    cmd;
  seg_pkg::seg_status_t sts;

  assign cfg_ch.ready = 1'b1;

  seg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  seg_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_now_time (in_ch.now_time),
    .cfg_we      (cfg_ch.valid),
    .cfg_idx     (cfg_ch.idx),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_level   (out_ch.level),
    .out_visible (out_ch.visible)
  );

endmodule

// File: design/seg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope checker
// Port-level checks on results, reset and request pacing.
// ----------------------------------------------------------------------------
module seg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [seg_pkg::LEVEL_W-1:0] out_level,
  input logic                        out_visible
);

  // The level never exceeds full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= seg_pkg::FULL_LEVEL))
    else $error("level above full scale");

  a_visible_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visible == (out_level != '0)))
    else $error("visible flag disagrees with level");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request is worked at a time, so acceptance closes the input.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_level) && $stable(out_visible)))
    else $error("stalled result changed");

endmodule

bind strobe_envelope_generator_unit seg_checker u_seg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_level   (out_ch.level),
  .out_visible (out_ch.visible)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe envelope generator testbench
// Drives time requests and register writes into the envelope unit, predicts
// each brightness level and visible flag, and checks every result in order
// while both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import seg_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_WAIT = 11;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 102;
  localparam int SIDE_SEND = 0;
  localparam int SIDE_TAKE = 1;

  typedef struct packed {
    logic [NOW_IN_W-1:0] now_time;
    logic [LEVEL_W-1:0]  level;
    logic                visible;
  } strobe_sample_t;

  logic clk = 1'b0;
  logic rst_n;

  seg_in_if  in_ch ();
  seg_out_if out_ch ();
  seg_cfg_if cfg_ch ();

  strobe_envelope_generator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the registers and the current cycle start.
  logic [31:0]            prd_period;
  logic [31:0]            prd_ramp_up;
  logic [31:0]            prd_hold;
  logic [31:0]            prd_ramp_down;
  logic signed [CS_W-1:0] prd_cycle_start;

  strobe_sample_t pending_levels[$];
  int             error_count = 0;
  int             quiet_cycles = 0;
  int             calm_left[2] = '{0, 0};
  bit             time_valid_up = 1'b0;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Wait before a request or an accept; now and then a calm stretch with no
  // waiting at all.
  function automatic int unsigned pick_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic strobe_sample_t strobe_predict(logic [31:0] now);
    strobe_sample_t   res;
    longint           offset;
    longint unsigned  d;
    longint unsigned  wraps;
    longint unsigned  up;
    longint unsigned  hold;
    longint unsigned  down;
    logic [LEVEL_W-1:0] lvl;
    offset = longint'({32'd0, now}) - longint'(prd_cycle_start);
    up = prd_ramp_up;
    hold = prd_hold;
    down = prd_ramp_down;
    lvl = '0;
    // A time before the cycle start leaves the start alone and gives dark.
    if (offset >= 0) begin
      d = offset;
      if (prd_period == 0) begin
        prd_cycle_start = {2'b00, now};
        d = 0;
      end else if (d >= prd_period) begin
        wraps = d / prd_period;
        prd_cycle_start = CS_W'(longint'(prd_cycle_start) + longint'(wraps * prd_period));
        d = d - wraps * prd_period;
      end
      if (d < up) begin
        lvl = LEVEL_W'((d * FULL_LEVEL) / up);
      end else begin
        d = d - up;
        if (d < hold) begin
          lvl = FULL_LEVEL;
        end else begin
          d = d - hold;
          if (d < down) lvl = LEVEL_W'(((down - d) * FULL_LEVEL) / down);
        end
      end
    end
    res.now_time = now;
    res.level = lvl;
    res.visible = (lvl != 0);
    return res;
  endfunction

  task automatic send_time(input logic [31:0] now);
    int unsigned gap;
    gap = pick_wait(SIDE_SEND);
    if (gap > 0) begin
      if (time_valid_up) begin
        in_ch.valid <= 1'b0;
        time_valid_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.now_time <= now;
    time_valid_up = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_levels.push_back(strobe_predict(now));
  endtask

  task automatic wait_for_results();
    if (time_valid_up) begin
      in_ch.valid <= 1'b0;
      time_valid_up = 1'b0;
    end
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // The write request stays up when another write follows right away.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_PERIOD_LEN:    prd_period = data;
      REG_START_PHASE:   prd_cycle_start = {{(CS_W - 32){data[31]}}, data};
      REG_RAMP_UP_LEN:   prd_ramp_up = data;
      REG_HOLD_LEN:      prd_hold = data;
      REG_RAMP_DOWN_LEN: prd_ramp_down = data;
      default: ;
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_envelope(input logic [31:0] period, input logic [31:0] phase,
                              input logic [31:0] up, input logic [31:0] hold,
                              input logic [31:0] down, input bit keep_phase);
    wait_for_results();
    write_reg(REG_PERIOD_LEN, period, 1'b0);
    if (!keep_phase) write_reg(REG_START_PHASE, phase, 1'b0);
    write_reg(REG_RAMP_UP_LEN, up, 1'b0);
    write_reg(REG_HOLD_LEN, hold, 1'b0);
    write_reg(REG_RAMP_DOWN_LEN, down, 1'b1);
  endtask

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(2, 64);
      4: return $urandom;
      default: return 32'hFFFF_FFFE;
    endcase
  endfunction

  function automatic logic [31:0] short_len(logic [31:0] period);
    if ($urandom_range(0, 5) == 0) return 32'd0;
    return $urandom_range(1, period / 2 + 1);
  endfunction

  // Default registers: ramp of 100 ticks, no hold, fall of 50, period 1250.
  task automatic test_reset_defaults();
    send_time(32'd0);
    send_time(32'd50);
    send_time(32'd99);
    send_time(32'd100);
    send_time(32'd125);
    send_time(32'd149);
    send_time(32'd150);
    send_time(32'd1249);
    send_time(32'd1250);
    send_time(32'd1250010);
    send_time(32'd5);
  endtask

  task automatic test_special_cases();
    // A hold write must not move the cycle start.
    wait_for_results();
    write_reg(REG_HOLD_LEN, 32'd200, 1'b1);
    send_time(32'd1250150);

    // Writes to unused indexes are dropped.
    wait_for_results();
    for (int j = int'(REG_RAMP_DOWN_LEN) + 1; j < (1 << CFG_IDX_W); j++)
      write_reg(CFG_IDX_W'(j), $urandom, j == (1 << CFG_IDX_W) - 1);
    send_time(32'd1251570);

    // Zero-length ramps become instant steps.
    set_envelope(32'd1000, 32'h8000_0000, 32'd0, 32'd300, 32'd0, 1'b0);
    send_time(32'd0);
    send_time(32'd352);
    send_time(32'd652);
    send_time(32'hFFFF_FFFF);

    // Zero period pins the cycle start to the request time.
    set_envelope(32'd0, 32'h7FFF_FFFF, 32'd0, 32'd5, 32'd64, 1'b0);
    send_time(32'd100);
    send_time(32'hFFFF_FFFF);

    set_envelope(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_time(32'h8000_0000);
    send_time(32'hFFFF_FFFF);
  endtask

  task automatic test_random_sweep();
    logic [31:0] period;
    logic [31:0] phase;
    logic [31:0] up;
    logic [31:0] hold;
    logic [31:0] down;
    logic [31:0] tick;
    logic [31:0] span;
    bit          keep_phase;
    tick = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          period = $urandom_range(1, 400);
          up = short_len(period);
          hold = short_len(period);
          down = short_len(period);
          phase = 32'($urandom_range(0, 1000)) - 32'd500;
        end
        2: begin
          period = corner_value();
          up = corner_value();
          hold = corner_value();
          down = corner_value();
          case ($urandom_range(0, 2))
            0: phase = 32'h8000_0000;
            1: phase = 32'h7FFF_FFFF;
            default: phase = $urandom;
          endcase
        end
        default: begin
          period = $urandom_range(1, 32'd1 << 20);
          up = $urandom_range(0, period);
          hold = $urandom_range(0, period);
          down = $urandom_range(0, period);
          phase = $urandom;
        end
      endcase
      keep_phase = (p > 0) && ($urandom_range(0, 3) == 0);
      set_envelope(period, phase, up, hold, down, keep_phase);
      if (!keep_phase) tick = phase + $urandom_range(0, 16);
      span = (period == 0) ? 32'd64 : (period >> 3) + 32'd1;
      // Mostly forward steps inside one period; a few long jumps, random
      // times and steps back in time.
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(0, 19))
          15, 16: tick += period * $urandom_range(2, 5000);
          17: tick = $urandom;
          18: tick -= $urandom_range(1, span);
          19: begin
            wait_for_results();
            tick += $urandom_range(0, span);
          end
          default: tick += $urandom_range(0, span);
        endcase
        send_time(tick);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.now_time <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx <= '0;
    cfg_ch.data <= '0;
    prd_period = PERIOD_LEN_RST;
    prd_ramp_up = RAMP_UP_LEN_RST;
    prd_hold = HOLD_LEN_RST;
    prd_ramp_down = RAMP_DOWN_LEN_RST;
    prd_cycle_start = {{(CS_W - 32){START_PHASE_RST[31]}}, START_PHASE_RST};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_random_sweep();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_ready
    int unsigned stall;
    forever begin
      stall = pick_wait(SIDE_TAKE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    strobe_sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        flag_error($sformatf("result with no request pending: level %0d visible %0b",
                             out_ch.level, out_ch.visible));
      end else begin
        want = pending_levels.pop_front();
        if (out_ch.level !== want.level)
          flag_error($sformatf("time %0d: level expected %0d, got %0d",
                               want.now_time, want.level, out_ch.level));
        if (out_ch.visible !== want.visible)
          flag_error($sformatf("time %0d: visible expected %0b, got %0b",
                               want.now_time, want.visible, out_ch.visible));
      end
    end
  end

  // Ends the run when no channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
